// File: hdl/assert_macros.svh
// assertion macros shared by the capture controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define DFCC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// property that holds at every edge outside reset
`define DFCC_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`endif

// File: hdl/dfcc_pkg.sv
// package: widths, codes and shared types of the frame capture controller
`default_nettype none
package dfcc_pkg;

   localparam int MAX_CHUNKS = 4096;
   localparam int CNT_W      = $clog2(MAX_CHUNKS);
   localparam int TOTAL_W    = 13;
   localparam int BYTES_W    = 16;
   localparam int OFFSET_W   = 24;
   localparam int IDX_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_CHUNKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_BYTES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_A_PRESENT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B_PRESENT    = 2'd3;

   // request kinds
   localparam logic REQ_CHUNK = 1'b0;
   localparam logic REQ_GIVE  = 1'b1;

   // buffer codes
   localparam logic [1:0] GIVE_A = 2'd0;
   localparam logic [1:0] GIVE_B = 2'd1;
   localparam logic       BUF_A  = 1'b0;
   localparam logic       BUF_B  = 1'b1;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_chunks;
      logic [BYTES_W-1:0] chunk_bytes;
      logic               a_present;
      logic               b_present;
   } cfg_type;

   typedef struct packed {
      logic                done_buffer;
      logic                frame_done;
      logic [IDX_W-1:0]    chunk_index;
      logic [OFFSET_W-1:0] dest_offset;
      logic                source_half;
      logic                copy_target;
      logic                copy_valid;
   } rsp_type;

endpackage
`default_nettype wire

// File: hdl/dfcc_csr.sv
// configuration register file of the frame capture controller
`default_nettype none
module dfcc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dfcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dfcc_pkg::CSR_DATA_W-1:0]  csr_data,
   output dfcc_pkg::cfg_type                     cfg
);

   dfcc_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_chunks <= dfcc_pkg::TOTAL_W'(1);
         cfg_ff.chunk_bytes  <= dfcc_pkg::BYTES_W'(4095);
         cfg_ff.a_present    <= 1'b1;
         cfg_ff.b_present    <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            dfcc_pkg::CSR_TOTAL_CHUNKS:
               cfg_ff.total_chunks <= csr_data[dfcc_pkg::TOTAL_W-1:0];
            dfcc_pkg::CSR_CHUNK_BYTES:
               cfg_ff.chunk_bytes  <= csr_data[dfcc_pkg::BYTES_W-1:0];
            dfcc_pkg::CSR_A_PRESENT:
               cfg_ff.a_present    <= csr_data[0];
            dfcc_pkg::CSR_B_PRESENT:
               cfg_ff.b_present    <= csr_data[0];
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// File: hdl/dfcc_engine.sv
// capture state and per-transaction result logic
`default_nettype none
module dfcc_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  dfcc_pkg::cfg_type      cfg,
   input  wire logic              fire,
   input  wire logic              req_kind,
   input  wire logic [1:0]        give_buffer,
   output dfcc_pkg::rsp_type      rsp
);

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_FILL_A = 2'd1,
      MODE_FILL_B = 2'd2
   } mode_type;

   mode_type                      mode_ff, mode_in;
   logic [dfcc_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                          enable_a_ff, enable_a_in;
   logic                          enable_b_ff, enable_b_in;

   logic [dfcc_pkg::CNT_W:0]      count_next;
   logic                          last;
   logic                          copy;
   logic                          target;
   logic [dfcc_pkg::CNT_W+dfcc_pkg::BYTES_W-1:0] product;

   always_comb begin
      count_next = dfcc_pkg::CNT_W'(count_ff) + (dfcc_pkg::CNT_W+1)'(1);
      last = (cfg.total_chunks != '0) &&
             ((dfcc_pkg::TOTAL_W'(count_ff)) == cfg.total_chunks - dfcc_pkg::TOTAL_W'(1));
      product = dfcc_pkg::CNT_W'(count_ff) * cfg.chunk_bytes;

      mode_in     = mode_ff;
      count_in    = count_ff;
      enable_a_in = enable_a_ff;
      enable_b_in = enable_b_ff;
      copy        = 1'b0;
      target      = dfcc_pkg::BUF_A;

      if (req_kind == dfcc_pkg::REQ_GIVE) begin
         if (give_buffer == dfcc_pkg::GIVE_A && cfg.a_present) begin
            enable_a_in = 1'b1;
         end else if (give_buffer == dfcc_pkg::GIVE_B && cfg.b_present) begin
            enable_b_in = 1'b1;
         end
      end else begin
         if ((dfcc_pkg::TOTAL_W'(count_next)) == cfg.total_chunks ||
             count_next >= (dfcc_pkg::CNT_W+1)'(dfcc_pkg::MAX_CHUNKS)) begin
            count_in = '0;
         end else begin
            count_in = count_next[dfcc_pkg::CNT_W-1:0];
         end

         unique case (mode_ff)
            MODE_FILL_A: begin
               copy   = 1'b1;
               target = dfcc_pkg::BUF_A;
            end
            MODE_FILL_B: begin
               copy   = 1'b1;
               target = dfcc_pkg::BUF_B;
            end
            default: begin
               // a frame only starts on chunk zero
               if (count_ff == '0) begin
                  if (enable_a_ff && cfg.a_present) begin
                     copy    = 1'b1;
                     target  = dfcc_pkg::BUF_A;
                     mode_in = MODE_FILL_A;
                  end else if (enable_b_ff && cfg.b_present) begin
                     copy    = 1'b1;
                     target  = dfcc_pkg::BUF_B;
                     mode_in = MODE_FILL_B;
                  end
               end
            end
         endcase

         if (copy && last) begin
            if (target == dfcc_pkg::BUF_A) begin
               enable_a_in = 1'b0;
            end else begin
               enable_b_in = 1'b0;
            end
            mode_in = MODE_IDLE;
         end
      end

      rsp = '0;
      if (req_kind == dfcc_pkg::REQ_CHUNK) begin
         rsp.copy_valid  = copy;
         rsp.copy_target = copy & target;
         rsp.source_half = count_ff[0];
         rsp.dest_offset = product[dfcc_pkg::OFFSET_W-1:0];
         rsp.chunk_index = dfcc_pkg::IDX_W'(count_ff);
         rsp.frame_done  = copy & last;
         rsp.done_buffer = copy & last & target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         count_ff    <= '0;
         enable_a_ff <= 1'b1;
         enable_b_ff <= 1'b1;
      end else if (fire) begin
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         enable_a_ff <= enable_a_in;
         enable_b_ff <= enable_b_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/double_frame_capture_controller_top.sv
// top level of the double frame capture controller
// Steers chunk copies from a ping-pong chunk buffer into two frame buffers.
// Every request transaction (a chunk-complete event, or the give-back of a
// frame buffer) yields exactly one response transaction, in order. The block
// takes one transaction per clock cycle when the response side keeps up; an
// accepted request lands in the input register, and its result moves into the
// result register behind the state update when that register is empty or is
// being drained by the response side.
// The capture state (mode, chunk counter, buffer enables) is updated in the
// same cycle a registered request is processed, so consecutive requests see
// each other's effect with no bubble. Configuration writes take effect at
// once and are meant to be issued while no transaction is in flight.
`default_nettype none
`include "assert_macros.svh"
module double_frame_capture_controller_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // [1:0] give_buffer, rest zero
   input  wire logic                              req_tuser,   // [0] req_type
   // response channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [0] copy_valid, [1] copy_target, [2] source_half, [26:3] dest_offset,
   // [38:27] chunk_index, [39] frame_done, [40] done_buffer, rest zero
   output logic [47:0]                            rsp_tdata,
   // configuration write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dfcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dfcc_pkg::CSR_DATA_W-1:0]   csr_data
);

   dfcc_pkg::cfg_type cfg;
   dfcc_pkg::rsp_type result;

   // input register
   logic       in_valid_ff;
   logic       in_kind_ff;
   logic [1:0] in_give_ff;

   // result register
   logic              out_valid_ff;
   dfcc_pkg::rsp_type out_data_ff;

   logic advance;

   // a held request moves on when the result register is empty or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_data_ff};

   dfcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dfcc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .fire        (advance),
      .req_kind    (in_kind_ff),
      .give_buffer (in_give_ff),
      .rsp         (result)
   );

   // request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser;
         in_give_ff <= req_tdata[1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   // a finished frame is always a commanded copy
   `DFCC_ASSERT_IMP(a_done_has_copy, clock, reset,
      out_valid_ff && out_data_ff.frame_done, out_data_ff.copy_valid,
      "frame done without a chunk copy")
   // the completed buffer is only named when a frame finished
   `DFCC_ASSERT_IMP(a_done_buffer_flag, clock, reset,
      out_valid_ff && out_data_ff.done_buffer, out_data_ff.frame_done,
      "done buffer set without frame done")
   // a full pipe behind a stalled response refuses new requests
   `DFCC_ASSERT_IMP(a_stall_backpressure, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_tready, !req_tready,
      "request accepted while pipe is full and stalled")
   // the state only moves when a result is produced in the next cycle
   `DFCC_ASSERT_IMP(a_advance_fills, clock, reset,
      advance, ##1 out_valid_ff,
      "processed transaction left no result")

endmodule
`default_nettype wire
